// ===== src/lirc_pkg.sv =====
// Shared constants, register codes and controller/datapath interface types
// for the linear interpolation rate converter. No dependencies.
`default_nettype none

package lirc_pkg;

  localparam int CHANNELS     = 2;
  localparam int SAMPLE_BITS  = 16;
  localparam int STEP_BITS    = 10;
  localparam int CLOCK_BITS   = 21;
  localparam int MAX_OUT      = 16;
  localparam int CNT_BITS     = $clog2(MAX_OUT);
  localparam int CH_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MN_BITS      = 2 * STEP_BITS;
  localparam int PROD_BITS    = STEP_BITS + SAMPLE_BITS + 1;
  localparam int DIV_BITS     = (PROD_BITS > CLOCK_BITS) ? PROD_BITS : CLOCK_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
  localparam int TDATA_BITS   = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
  localparam int FILL_BITS    = 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_STEP  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_STEP = 2'd1;

  localparam logic [STEP_BITS-1:0] INPUT_STEP_RESET  = 10'd9;
  localparam logic [STEP_BITS-1:0] OUTPUT_STEP_RESET = 10'd5;

  localparam logic [FILL_BITS-1:0] FILL_EMPTY = 2'd0;
  localparam logic [FILL_BITS-1:0] FILL_ONE   = 2'd1;
  localparam logic [FILL_BITS-1:0] FILL_TWO   = 2'd2;

  typedef struct packed {
    logic               load_first;
    logic               load_second;
    logic               shift;
    logic               reduce;
    logic               mod_start;
    logic               frac_load;
    logic               mul;
    logic               ch_start;
    logic               ch_store;
    logic               emit;
    logic               last;
    logic [CH_BITS-1:0] ch;
  } lirc_cmd_t;

  typedef struct packed {
    logic [FILL_BITS-1:0] fill;
    logic                 oc_gt_ic;
    logic                 next_gt_ic;
    logic                 div_done;
    logic                 out_free;
  } lirc_status_t;

endpackage

`default_nettype wire

// ===== src/lirc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on lirc_pkg for the dividend and divisor widths.
`default_nettype none

module lirc_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [lirc_pkg::DIV_BITS-1:0]  dividend,
  input  wire logic [lirc_pkg::STEP_BITS-1:0] divisor,
  output logic                                busy,
  output logic                                done,
  output logic [lirc_pkg::DIV_BITS-1:0]       quotient,
  output logic [lirc_pkg::STEP_BITS-1:0]      remainder
);
  import lirc_pkg::*;

  logic [DIV_BITS-1:0]     quo;
  logic [STEP_BITS-1:0]    rem;
  logic [STEP_BITS-1:0]    dvs;
  logic [DIV_CNT_BITS-1:0] count;
  logic [STEP_BITS:0]      trial;
  logic [STEP_BITS:0]      diff;
  logic                    fits;

  assign trial = {rem, quo[DIV_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_BITS'(DIV_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_BITS-2:0], fits};
      rem <= fits ? diff[STEP_BITS-1:0] : trial[STEP_BITS-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("divider done without a preceding run");

endmodule

`default_nettype wire

// ===== src/lirc_datapath.sv =====
// Datapath: step registers, sample pair, clocks, multiplier, shared divider
// and output register. Depends on lirc_pkg and lirc_div.
`default_nettype none

module lirc_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lirc_pkg::lirc_cmd_t                 cmd,
  output lirc_pkg::lirc_status_t                   status,
  input  wire logic [lirc_pkg::TDATA_BITS-1:0]     s_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [lirc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lirc_pkg::STEP_BITS-1:0]      cfg_data,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [lirc_pkg::TDATA_BITS-1:0]          m_tdata,
  output logic                                     m_tlast
);
  import lirc_pkg::*;

  logic [STEP_BITS-1:0]  input_step;
  logic [STEP_BITS-1:0]  output_step;
  logic [STEP_BITS-1:0]  m_eff;
  logic [STEP_BITS-1:0]  n_eff;
  logic [MN_BITS-1:0]    prod_mn;
  logic [CLOCK_BITS-1:0] mn_ext;
  logic [CLOCK_BITS-1:0] m_ext;
  logic [CLOCK_BITS-1:0] n_ext;
  logic [CLOCK_BITS-1:0] input_clock;
  logic [CLOCK_BITS-1:0] output_clock;
  logic [CLOCK_BITS-1:0] oc_next;
  logic [FILL_BITS-1:0]  fill_count;

  logic signed [SAMPLE_BITS-1:0] in_sample [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] earlier_sample [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] later_sample [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] result [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] out_data [CHANNELS];

  logic [STEP_BITS-1:0]         frac;
  logic signed [SAMPLE_BITS:0]  diff_sel;
  logic signed [STEP_BITS:0]    frac_s;
  logic signed [PROD_BITS:0]    product;
  logic [PROD_BITS:0]           prod_abs;
  logic                         prod_neg;
  logic [DIV_BITS-1:0]          div_dividend;
  logic                         div_busy;
  logic                         div_done;
  logic [DIV_BITS-1:0]          quotient;
  logic [STEP_BITS-1:0]         remainder;
  logic signed [SAMPLE_BITS+1:0] q_ext;
  logic signed [SAMPLE_BITS+1:0] e_ext;
  logic signed [SAMPLE_BITS+1:0] sum;

  // A step of zero behaves as a step of one.
  assign m_eff  = (input_step == '0) ? STEP_BITS'(1) : input_step;
  assign n_eff  = (output_step == '0) ? STEP_BITS'(1) : output_step;
  assign mn_ext = CLOCK_BITS'(prod_mn);
  assign m_ext  = CLOCK_BITS'(m_eff);
  assign n_ext  = CLOCK_BITS'(n_eff);
  assign oc_next = output_clock + m_ext;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      in_sample[c] = s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  assign diff_sel = $signed({later_sample[cmd.ch][SAMPLE_BITS-1], later_sample[cmd.ch]})
                  - $signed({earlier_sample[cmd.ch][SAMPLE_BITS-1], earlier_sample[cmd.ch]});
  assign frac_s   = $signed({1'b0, frac});
  assign prod_neg = product[PROD_BITS];
  assign prod_abs = prod_neg ? -product : product;

  assign div_dividend = cmd.mod_start ? DIV_BITS'(output_clock)
                                      : DIV_BITS'(prod_abs[PROD_BITS-1:0]);

  lirc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mod_start | cmd.ch_start),
    .dividend  (div_dividend),
    .divisor   (n_eff),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign q_ext = $signed({1'b0, quotient[SAMPLE_BITS:0]});
  assign e_ext = $signed({{2{earlier_sample[cmd.ch][SAMPLE_BITS-1]}}, earlier_sample[cmd.ch]});
  assign sum   = prod_neg ? (e_ext - q_ext) : (e_ext + q_ext);

  // Control state: steps, clocks, fill level and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_step   <= INPUT_STEP_RESET;
      output_step  <= OUTPUT_STEP_RESET;
      input_clock  <= '0;
      output_clock <= '0;
      fill_count   <= FILL_EMPTY;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INPUT_STEP:  input_step  <= cfg_data;
          REG_OUTPUT_STEP: output_step <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_first) begin
        input_clock  <= '0;
        output_clock <= '0;
        fill_count   <= FILL_ONE;
      end
      if (cmd.load_second) begin
        fill_count <= FILL_TWO;
      end
      if (cmd.reduce) begin
        if (input_clock > mn_ext) begin
          input_clock  <= input_clock - mn_ext + n_ext;
          output_clock <= (output_clock >= mn_ext) ? (output_clock - mn_ext) : '0;
        end else begin
          input_clock <= input_clock + n_ext;
        end
      end
      if (cmd.emit) begin
        output_clock <= oc_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_mn <= m_eff * n_eff;
    for (int c = 0; c < CHANNELS; c++) begin
      if (cmd.load_first) begin
        earlier_sample[c] <= in_sample[c];
        later_sample[c]   <= '0;
      end else if (cmd.load_second) begin
        later_sample[c] <= in_sample[c];
      end else if (cmd.shift) begin
        earlier_sample[c] <= later_sample[c];
        later_sample[c]   <= in_sample[c];
      end
    end
    if (cmd.frac_load) begin
      frac <= remainder;
    end
    if (cmd.mul) begin
      product <= frac_s * diff_sel;
    end
    if (cmd.ch_store) begin
      result[cmd.ch] <= sum[SAMPLE_BITS-1:0];
    end
    if (cmd.emit) begin
      out_data <= result;
      m_tlast  <= cmd.last;
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = out_data[c];
    end
  end

  always_comb begin
    status.fill       = fill_count;
    status.oc_gt_ic   = (output_clock > input_clock);
    status.next_gt_ic = (oc_next > input_clock);
    status.div_done   = div_done;
    status.out_free   = !m_tvalid || m_tready;
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over an item not yet taken");
  a_store_after_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.ch_store || cmd.frac_load) |-> (div_done && !div_busy))
    else $error("divider result used before it is complete");

endmodule

`default_nettype wire

// ===== src/lirc_ctrl.sv =====
// Controller state machine: sequences fill, clock update and the per-output
// modulo, multiply and divide steps. Depends on lirc_pkg.
`default_nettype none

module lirc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic                   restart,
  output lirc_pkg::lirc_cmd_t         cmd,
  input  wire lirc_pkg::lirc_status_t status
);
  import lirc_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_REDUCE    = 4'd1;
  localparam logic [3:0] S_CHECK     = 4'd2;
  localparam logic [3:0] S_MOD_START = 4'd3;
  localparam logic [3:0] S_MOD_WAIT  = 4'd4;
  localparam logic [3:0] S_MUL       = 4'd5;
  localparam logic [3:0] S_CH_START  = 4'd6;
  localparam logic [3:0] S_CH_WAIT   = 4'd7;
  localparam logic [3:0] S_EMIT      = 4'd8;

  localparam logic [CH_BITS-1:0]  LAST_CH  = CH_BITS'(CHANNELS - 1);
  localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(MAX_OUT - 1);

  logic [3:0]          state, state_next;
  logic [CH_BITS-1:0]  ch, ch_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;

  always_comb begin
    cmd        = '0;
    cmd.ch     = ch;
    state_next = state;
    ch_next    = ch;
    cnt_next   = cnt;
    s_tready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cnt_next = '0;
          if (restart || status.fill == FILL_EMPTY) begin
            cmd.load_first = 1'b1;
          end else if (status.fill == FILL_ONE) begin
            cmd.load_second = 1'b1;
            state_next      = S_CHECK;
          end else begin
            cmd.shift  = 1'b1;
            state_next = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.oc_gt_ic ? S_IDLE : S_MOD_START;
      end
      S_MOD_START: begin
        cmd.mod_start = 1'b1;
        state_next    = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (status.div_done) begin
          cmd.frac_load = 1'b1;
          ch_next       = '0;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CH_START;
      end
      S_CH_START: begin
        cmd.ch_start = 1'b1;
        state_next   = S_CH_WAIT;
      end
      S_CH_WAIT: begin
        if (status.div_done) begin
          cmd.ch_store = 1'b1;
          if (ch == LAST_CH) begin
            state_next = S_EMIT;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = (cnt == LAST_CNT) || status.next_gt_ic;
          cnt_next   = cnt + 1'b1;
          state_next = cmd.last ? S_IDLE : S_MOD_START;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      cnt   <= cnt_next;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_MOD_WAIT || state == S_CH_WAIT))
    else $error("divider finished outside a wait state");
  a_cap_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cnt == LAST_CNT) |-> cmd.last)
    else $error("more results than allowed for one item");

endmodule

`default_nettype wire

// ===== src/linear_interp_rate_converter.sv =====
// Each result runs the shared bit-serial divider through all DIV_BITS quotient bits, once
// for the output clock modulo and again for each channel quotient.
// Throughput: one item at a time; up to 16 results per item, the rest follow later items.
// Reset (synchronous, active high) clears clocks, fill level and handshakes and restores
// input_step to 9 and output_step to 5; no clearing pass.
`default_nettype none

module linear_interp_rate_converter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input samples. s_tdata, from the lowest bit: sample_ch0, sample_ch1.
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [lirc_pkg::TDATA_BITS-1:0]     s_tdata,
  // s_tuser: restart.
  input  wire logic                                s_tuser,
  // Results. m_tdata, from the lowest bit: out_ch0, out_ch1. m_tlast: last.
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [lirc_pkg::TDATA_BITS-1:0]          m_tdata,
  output logic                                     m_tlast,
  // Configuration writes: index 0 is input_step, index 1 is output_step.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lirc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lirc_pkg::STEP_BITS-1:0]      cfg_data
);
  import lirc_pkg::*;

  lirc_cmd_t    cmd;
  lirc_status_t status;

  // Step registers are always writable, so software must write them only while idle.
  assign cfg_ready = 1'b1;

  // The controller walks each item through fill, clock update and the output loop,
  // while the datapath holds all sample and clock state and the output register.
  lirc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .restart  (s_tuser),
    .cmd      (cmd),
    .status   (status)
  );

  lirc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== bench/lirc_result_checker.sv =====
// Result checker for the linear interpolation rate converter: watches the input, output
// and register write channels, predicts every interpolated output and compares.
// Depends on lirc_pkg for widths and register indexes.
module lirc_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [lirc_pkg::TDATA_BITS-1:0]     s_tdata,
  input  logic                                s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [lirc_pkg::TDATA_BITS-1:0]     m_tdata,
  input  logic                                m_tlast,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [lirc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lirc_pkg::STEP_BITS-1:0]      cfg_data,
  input  logic                                end_of_test,
  output int                                  pending,
  output int                                  errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import lirc_pkg::*;

  localparam int unsigned CLOCK_MASK = (1 << CLOCK_BITS) - 1;

  typedef struct packed {
    logic                                  last;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] ch;
  } interp_out_t;

  interp_out_t interp_q[$];

  logic [STEP_BITS-1:0]          in_step;
  logic [STEP_BITS-1:0]          out_step;
  logic signed [SAMPLE_BITS-1:0] earlier[CHANNELS];
  logic signed [SAMPLE_BITS-1:0] later[CHANNELS];
  int unsigned                   in_clock;
  int unsigned                   out_clock;
  logic [FILL_BITS-1:0]          fill;
  bit                            drained = 1'b0;
  int                            queued = 0;
  int                            mismatch_count = 0;

  assign pending = queued;
  assign errors  = mismatch_count;

  task automatic report_mismatch(input string what);
    mismatch_count = mismatch_count + 1;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Works out the outputs that one input sample releases and queues them in order.
  task automatic resample_item(input logic restart, input logic [TDATA_BITS-1:0] data);
    int unsigned m;
    int unsigned n;
    int unsigned mn;
    int unsigned ic;
    int unsigned oc;
    int          count;
    longint      frac;
    longint      diff;
    longint      val;
    interp_out_t res;
    bit          have_res;
    m  = (in_step == '0) ? 1 : int'(in_step);
    n  = (out_step == '0) ? 1 : int'(out_step);
    mn = m * n;
    // A restart, or any sample while the pair is empty, only loads the earlier sample.
    if (restart || fill == FILL_EMPTY) begin
      for (int c = 0; c < CHANNELS; c++) begin
        earlier[c] = data[c*SAMPLE_BITS +: SAMPLE_BITS];
        later[c]   = '0;
      end
      in_clock  = 0;
      out_clock = 0;
      fill      = FILL_ONE;
      return;
    end
    ic = in_clock;
    oc = out_clock;
    if (fill == FILL_ONE) begin
      for (int c = 0; c < CHANNELS; c++) later[c] = data[c*SAMPLE_BITS +: SAMPLE_BITS];
      fill = FILL_TWO;
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        earlier[c] = later[c];
        later[c]   = data[c*SAMPLE_BITS +: SAMPLE_BITS];
      end
      if (ic > mn) begin
        ic = ic - mn;
        oc = (oc >= mn) ? oc - mn : 0;
      end
      ic = (ic + n) & CLOCK_MASK;
    end
    count    = 0;
    have_res = 1'b0;
    res      = '0;
    while (count < MAX_OUT && oc <= ic) begin
      if (have_res) interp_q.push_back(res);
      frac = longint'(oc % n);
      for (int c = 0; c < CHANNELS; c++) begin
        diff = longint'(later[c]) - longint'(earlier[c]);
        val  = longint'(earlier[c]) + (frac * diff) / longint'(n);
        res.ch[c] = val[SAMPLE_BITS-1:0];
      end
      res.last = 1'b0;
      have_res = 1'b1;
      oc = (oc + m) & CLOCK_MASK;
      count++;
    end
    if (have_res) begin
      res.last = 1'b1;
      interp_q.push_back(res);
    end
    in_clock  = ic;
    out_clock = oc;
  endtask

  task automatic check_result();
    interp_out_t exp_out;
    logic [SAMPLE_BITS-1:0] got;
    if (interp_q.size() == 0) begin
      report_mismatch($sformatf("output %h last %b with nothing expected", m_tdata, m_tlast));
      return;
    end
    exp_out = interp_q.pop_front();
    for (int c = 0; c < CHANNELS; c++) begin
      got = m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
      if (got !== exp_out.ch[c])
        report_mismatch($sformatf("out_ch%0d is %0d, expected %0d", c,
                                  $signed(got), $signed(exp_out.ch[c])));
    end
    if (m_tlast !== exp_out.last)
      report_mismatch($sformatf("last is %b, expected %b", m_tlast, exp_out.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_step   = INPUT_STEP_RESET;
      out_step  = OUTPUT_STEP_RESET;
      in_clock  = 0;
      out_clock = 0;
      fill      = FILL_EMPTY;
      for (int c = 0; c < CHANNELS; c++) begin
        earlier[c] = '0;
        later[c]   = '0;
      end
      interp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INPUT_STEP:  in_step = cfg_data;
          REG_OUTPUT_STEP: out_step = cfg_data;
          default: ;
        endcase
      end
      // Outputs taken at this edge belong to items accepted earlier.
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) resample_item(s_tuser, s_tdata);
      if (end_of_test && !drained) begin
        drained = 1'b1;
        foreach (interp_q[i])
          report_mismatch($sformatf("expected output %h never arrived", interp_q[i].ch));
        interp_q.delete();
      end
    end
    queued = interp_q.size();
  end

endmodule

// ===== bench/tb_linear_interp_rate_converter.sv =====
// Top of the rate converter testbench: clock, reset, stimulus, idling and the verdict.
// Depends on lirc_pkg, linear_interp_rate_converter and lirc_result_checker.
module tb_linear_interp_rate_converter;
  timeunit 1ns;
  timeprecision 1ps;
  import lirc_pkg::*;

  // No handshake on any channel for this many cycles means the block is stuck. The slowest
  // correct stretch is one result plus a long random receiver stall.
  localparam int WATCHDOG_LIMIT = 5000;
  // An item that yields no output may still be in flight when the queue runs empty.
  localparam int QUIET_CYCLES   = 10;
  // After the last expected output, watch a little longer for strays.
  localparam int TAIL_CYCLES    = 200;
  localparam int PHASES         = 10;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int RANDOM_STEP    = -1;
  // Phase in which the step ratio is not held to at most fifteen.
  localparam int FREE_RATIO_PHASE = 7;
  // Idling modes change at these phases.
  localparam int SWAP_IDLE_PHASE = 4;
  localparam int NO_IDLE_PHASE   = 7;
  // An index the block has no register for; a write there must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [TDATA_BITS-1:0]     s_tdata = '0;   // sample_ch0, sample_ch1
  logic                      s_tuser = 1'b0; // restart
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [TDATA_BITS-1:0]     m_tdata;        // out_ch0, out_ch1
  logic                      m_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [STEP_BITS-1:0]      cfg_data = '0;
  logic                      end_of_test = 1'b0;
  int                        pending;
  int                        errors;
  int                        quiet_cycles = 0;
  int                        send_idle_pct = 24;
  int                        recv_idle_pct = 46;

  // Step pairs per random phase; RANDOM_STEP draws a fresh pair.
  int phase_in_step[PHASES]  = '{9, 160, 1023, RANDOM_STEP, 1, 1, RANDOM_STEP,
                                 RANDOM_STEP, 2, 147};
  int phase_out_step[PHASES] = '{5, 147, 1, RANDOM_STEP, 1, 15, RANDOM_STEP,
                                 RANDOM_STEP, 31, 160};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  linear_interp_rate_converter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  lirc_result_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .end_of_test(end_of_test),
    .pending    (pending),
    .errors     (errors)
  );

  // The receiver stalls at random; with recv_idle_pct at zero it is always ready.
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // The watchdog restarts its count whenever any channel moves an item.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Offers one input item, after an optional random gap, and returns at the falling edge
  // after it was taken. The valid is left high so that back-to-back items need no
  // second assignment in the same step; whoever stops sending lowers it.
  task automatic send_item(input logic restart, input logic [SAMPLE_BITS-1:0] ch0,
                           input logic [SAMPLE_BITS-1:0] ch1);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= restart;
    s_tdata  <= {ch1, ch0};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [STEP_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Registers change only while the block is idle: all expected outputs are in and an
  // item that yields nothing has had time to finish.
  task automatic set_steps(input logic [STEP_BITS-1:0] m, input logic [STEP_BITS-1:0] n,
                           input bit poke_unused);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    write_reg(REG_INPUT_STEP, m);
    write_reg(REG_OUTPUT_STEP, n);
    if (poke_unused) write_reg(REG_UNUSED, STEP_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Samples lean toward the extremes and toward small values, where rounding of the
  // interpolation is easiest to get wrong; the rest are uniform over the full range.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SAMPLE_BITS'($urandom_range(16) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int m_sel;
    int n_sel;
    int n_top;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset steps 9 and 5 first. A sample without restart right after
    // reset must still start a record, and the second sample returns the first one.
    send_item(1'b0, 16'h7FFF, 16'h8000);
    send_item(1'b0, 16'h8000, 16'h7FFF);
    // Full-scale swings in both directions, so the difference needs a 17th bit and
    // negative products must truncate toward zero.
    send_item(1'b0, 16'h0000, 16'h0000);
    send_item(1'b0, 16'h7FFF, 16'h8000);
    send_item(1'b0, 16'hFFFF, 16'h0001);
    send_item(1'b0, 16'h8000, 16'h7FFF);
    send_item(1'b0, 16'd1234, -16'sd4321);
    // A restart in the middle of a record refills the pair.
    send_item(1'b1, 16'd12345, -16'sd12345);
    send_item(1'b0, -16'sd20000, 16'sd20000);
    send_item(1'b0, 16'sd5, -16'sd5);
    send_item(1'b0, 16'h0000, 16'h0000);

    // The largest ratio the rates allow gives fifteen outputs per input.
    set_steps(10'd1, 10'd15, 1'b0);
    repeat (4) send_item(1'b0, pick_sample(), pick_sample());
    // Beyond that, outputs past the sixteenth wait for the next input.
    set_steps(10'd1, 10'd1023, 1'b0);
    repeat (3) send_item(1'b0, pick_sample(), pick_sample());
    // Zero steps act as one; a write to an unused index must have no effect.
    set_steps(10'd0, 10'd0, 1'b1);
    repeat (3) send_item(1'b0, pick_sample(), pick_sample());
    // Both steps at their top value push the clocks near their widest.
    set_steps(10'd1023, 10'd1023, 1'b0);
    repeat (3) send_item(1'b0, pick_sample(), pick_sample());

    // Random part: mostly continuous records with random content and an occasional
    // restart, under a different step pair in each phase.
    for (int p = 0; p < PHASES; p++) begin
      if (p == SWAP_IDLE_PHASE) begin
        send_idle_pct = 46;
        recv_idle_pct = 24;
      end
      if (p == NO_IDLE_PHASE) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase_in_step[p] == RANDOM_STEP) begin
        m_sel = $urandom_range(1023, 1);
        n_top = (p == FREE_RATIO_PHASE || 15 * m_sel > 1023) ? 1023 : 15 * m_sel;
        n_sel = $urandom_range(n_top, 1);
      end else begin
        m_sel = phase_in_step[p];
        n_sel = phase_out_step[p];
      end
      set_steps(STEP_BITS'(m_sel), STEP_BITS'(n_sel), 1'b0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_item($urandom_range(24) == 0, pick_sample(), pick_sample());
    end

    // Drain: wait until every expected output has come, then watch for strays.
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(negedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lirc_pkg.sv
src/lirc_div.sv
src/lirc_datapath.sv
src/lirc_ctrl.sv
src/linear_interp_rate_converter.sv
bench/lirc_result_checker.sv
bench/tb_linear_interp_rate_converter.sv
